FILE: rtl/msbs_pkg.sv
`timescale 1ns / 1ps
// Package for the multi-signature byte scanner: word types, opcodes,
// default sizes and the command struct between the top level and the slot bank.
// No dependencies.
package msbs_pkg;

  // Default sizes, handed to the top level's parameters.
  localparam int NUM_SLOTS_DEF   = 16;
  localparam int MAX_SIG_LEN_DEF = 32;

  // Reset value of the scan limit register.
  localparam logic [15:0] SCAN_LIMIT_RST = 16'd10000;

  // At most this many results are reported for one data byte.
  localparam int MAX_OUT = 16;
  localparam int CNT_W   = $clog2(MAX_OUT);

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_SET_LEN = 2'd1,
    OP_SCAN    = 2'd2,
    OP_BEGIN   = 2'd3
  } msbs_op_t;

  typedef struct packed {
    msbs_op_t    opcode;
    logic [3:0]  slot;
    logic [4:0]  byte_pos;
    logic [7:0]  byte_value;
    logic [5:0]  sig_len;
  } msbs_in_t;

  typedef struct packed {
    logic [3:0]  match_slot;
    logic [15:0] start_offset;
    logic [5:0]  match_len;
    logic        last;
  } msbs_out_t;

  // Strobes from the top level's control to the slot bank.
  typedef struct packed {
    logic load;
    logic set_len;
    logic scan;
    logic clear;
  } msbs_cmd_t;

endpackage

FILE: rtl/multi_signature_byte_scanner.sv
`timescale 1ns / 1ps
// Multi-signature byte scanner, top level. Depends on msbs_pkg, msbs_slot_bank, msbs_emitter.
// Path: input register, emitter pending register, output register.
// Throughput: one input word per cycle when not stalled; a data byte that completes k
// signatures holds the input while the emitter sends its results, one per cycle.
// Reset (synchronous, rst_n low): slot lengths, match vectors and position clear,
// scan limit returns to 10000; signature bytes keep their contents.
module multi_signature_byte_scanner import msbs_pkg::*; #(
  parameter int NUM_SLOTS   = NUM_SLOTS_DEF,
  parameter int MAX_SIG_LEN = MAX_SIG_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  msbs_in_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output msbs_out_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  localparam int LEN_W = $clog2(MAX_SIG_LEN + 1);

  logic                              a_vld_r;
  msbs_in_t                          a_item_r;
  logic [15:0]                       pos_r;
  logic [15:0]                       limit_r;
  logic                              take_ok;
  logic                              go;
  msbs_cmd_t                         cmd;
  logic [NUM_SLOTS-1:0]              hits;
  logic [NUM_SLOTS-1:0][LEN_W-1:0]   lens;

  // Input register: holds while the emitter still works on an earlier byte.
  assign go       = a_vld_r && take_ok;
  assign in_stall = a_vld_r && !take_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      a_vld_r <= 1'b1;
    end else if (go) begin
      a_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      a_item_r <= in_data;
    end
  end

  // Decode the held word; data bytes at or past the limit do nothing.
  always_comb begin
    cmd = '0;
    unique case (a_item_r.opcode)
      OP_LOAD:    cmd.load    = go;
      OP_SET_LEN: cmd.set_len = go;
      OP_SCAN:    cmd.scan    = go && (pos_r < limit_r);
      OP_BEGIN:   cmd.clear   = go;
      default:    cmd         = '0;
    endcase
  end

  // Data position within the current scan.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (cmd.clear) begin
      pos_r <= '0;
    end else if (cmd.scan) begin
      pos_r <= pos_r + 16'd1;
    end
  end

  // Scan limit register; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= SCAN_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      limit_r <= cfg_data;
    end
  end

  msbs_slot_bank #(
    .NUM_SLOTS   (NUM_SLOTS),
    .MAX_SIG_LEN (MAX_SIG_LEN)
  ) u_bank (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .item  (a_item_r),
    .hits  (hits),
    .lens  (lens)
  );

  msbs_emitter #(
    .NUM_SLOTS   (NUM_SLOTS),
    .MAX_SIG_LEN (MAX_SIG_LEN)
  ) u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (cmd.scan && (hits != '0)),
    .hits      (hits),
    .lens      (lens),
    .pos       (pos_r),
    .take_ok   (take_ok),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: rtl/msbs_slot_bank.sv
`timescale 1ns / 1ps
// Signature slot bank: signature bytes, slot lengths and shift-and partial
// match vectors, with all slots compared against the data byte in parallel.
// Depends on msbs_pkg.
module msbs_slot_bank import msbs_pkg::*; #(
  parameter int NUM_SLOTS   = NUM_SLOTS_DEF,
  parameter int MAX_SIG_LEN = MAX_SIG_LEN_DEF,
  localparam int LEN_W      = $clog2(MAX_SIG_LEN + 1)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  msbs_cmd_t                         cmd,
  input  msbs_in_t                          item,
  output logic [NUM_SLOTS-1:0]              hits,
  output logic [NUM_SLOTS-1:0][LEN_W-1:0]   lens
);

  // Requested length, saturated to the longest signature.
  logic [LEN_W-1:0] sat_len;

  always_comb begin
    if (int'(item.sig_len) > MAX_SIG_LEN) begin
      sat_len = LEN_W'(MAX_SIG_LEN);
    end else begin
      sat_len = LEN_W'(item.sig_len);
    end
  end

  for (genvar s = 0; s < NUM_SLOTS; s++) begin : g_slot
    logic [7:0]             sig_r [MAX_SIG_LEN];
    logic [LEN_W-1:0]       len_r;
    logic [MAX_SIG_LEN-1:0] pm_r;
    logic [MAX_SIG_LEN-1:0] pm_nxt;
    logic                   slot_hit;
    logic                   slot_sel;

    assign slot_sel = (int'(item.slot) == s);

    // Signature bytes hold no reset; each byte is written only by its own load.
    for (genvar i = 0; i < MAX_SIG_LEN; i++) begin : g_byte
      always_ff @(posedge clk) begin
        if (cmd.load && slot_sel && (int'(item.byte_pos) == i)) begin
          sig_r[i] <= item.byte_value;
        end
      end
    end

    // Shift-and step: extend every partial match by one byte and start a new one.
    always_comb begin
      logic [MAX_SIG_LEN-1:0] eq;
      logic [MAX_SIG_LEN-1:0] in_len;
      logic [MAX_SIG_LEN-1:0] at_end;
      eq     = '0;
      in_len = '0;
      at_end = '0;
      for (int i = 0; i < MAX_SIG_LEN; i++) begin
        eq[i]     = (sig_r[i] == item.byte_value);
        in_len[i] = (LEN_W'(i) < len_r);
        at_end[i] = (LEN_W'(i + 1) == len_r);
      end
      pm_nxt   = ((pm_r << 1) | MAX_SIG_LEN'(1)) & eq & in_len;
      slot_hit = |(pm_nxt & at_end);
    end

    // Length and vector state; a length change or a new scan drops the vector.
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        len_r <= '0;
        pm_r  <= '0;
      end else if (cmd.set_len && slot_sel) begin
        len_r <= sat_len;
        pm_r  <= '0;
      end else if (cmd.clear) begin
        pm_r <= '0;
      end else if (cmd.scan) begin
        pm_r <= pm_nxt;
      end
    end

    assign hits[s] = slot_hit;
    assign lens[s] = len_r;
  end

endmodule

FILE: rtl/msbs_emitter.sv
`timescale 1ns / 1ps
// Result emitter: holds the hit set of one data byte and sends its matches,
// lowest slot first, one per cycle unless the output stalls, through the
// output register. Depends on msbs_pkg.
module msbs_emitter import msbs_pkg::*; #(
  parameter int NUM_SLOTS   = NUM_SLOTS_DEF,
  parameter int MAX_SIG_LEN = MAX_SIG_LEN_DEF,
  localparam int LEN_W      = $clog2(MAX_SIG_LEN + 1),
  localparam int SLOT_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              load,
  input  logic [NUM_SLOTS-1:0]              hits,
  input  logic [NUM_SLOTS-1:0][LEN_W-1:0]   lens,
  input  logic [15:0]                       pos,
  output logic                              take_ok,
  output logic                              out_valid,
  input  logic                              out_stall,
  output msbs_out_t                         out_data
);

  logic                              p_vld_r;
  logic [NUM_SLOTS-1:0]              p_mask_r;
  logic [NUM_SLOTS-1:0][LEN_W-1:0]   p_len_r;
  logic [15:0]                       p_pos_r;
  logic [CNT_W-1:0]                  p_cnt_r;
  logic                              out_valid_r;
  msbs_out_t                         out_data_r;

  logic [NUM_SLOTS-1:0] sel_oh;
  logic [NUM_SLOTS-1:0] rem;
  logic [SLOT_W-1:0]    sel;
  logic [LEN_W-1:0]     sel_len;
  logic                 emit;
  logic                 final_hit;

  // Isolate the lowest pending slot and pick its index and length.
  always_comb begin
    sel_oh  = p_mask_r & (~p_mask_r + NUM_SLOTS'(1));
    rem     = p_mask_r & ~sel_oh;
    sel     = '0;
    sel_len = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (sel_oh[i]) begin
        sel     = sel | SLOT_W'(i);
        sel_len = sel_len | p_len_r[i];
      end
    end
  end

  assign emit      = p_vld_r && (!out_valid_r || !out_stall);
  assign final_hit = (rem == '0) || (p_cnt_r == CNT_W'(MAX_OUT - 1));
  assign take_ok   = !p_vld_r || (emit && final_hit);

  // Pending hit set of one data byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
    end else if (load) begin
      p_vld_r <= 1'b1;
    end else if (emit && final_hit) begin
      p_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      p_mask_r <= hits;
      p_len_r  <= lens;
      p_pos_r  <= pos;
      p_cnt_r  <= '0;
    end else if (emit) begin
      p_mask_r <= rem;
      p_cnt_r  <= p_cnt_r + CNT_W'(1);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r.match_slot   <= 4'(sel);
      out_data_r.start_offset <= p_pos_r + 16'd1 - 16'(sel_len);
      out_data_r.match_len    <= 6'(sel_len);
      out_data_r.last         <= final_hit;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: rtl/msbs_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the multi-signature byte scanner, bound to the top level.
// Depends on msbs_pkg and multi_signature_byte_scanner.
module msbs_checker import msbs_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input msbs_out_t   out_data
);

  // A stalled result word stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // Results of one byte follow one another without a gap.
  a_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.last |=> out_valid)
    else $error("gap inside the results of one byte");

  // A reported match is never empty.
  a_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.match_len != 6'd0)
    else $error("match of zero length");

  // A match ends inside the 16-bit data range.
  a_span: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (17'(out_data.start_offset) + 17'(out_data.match_len)) <= 17'd65535)
    else $error("match extends beyond the data range");

endmodule

bind multi_signature_byte_scanner msbs_checker u_msbs_checker (.*);
